// ===== sv/pia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_pkg
// Shared types, opcodes and helpers for the P-code integer ALU pipeline.
// ----------------------------------------------------------------------------
package pia_pkg;

    localparam int DW        = 64;
    localparam int DIV_STEPS = 64;

    // Operation codes
    typedef enum logic [5:0] {
        OP_COPY = 6'd0,  OP_ADD = 6'd1,   OP_SUB = 6'd2,   OP_CARRY = 6'd3,
        OP_SCARRY = 6'd4, OP_SBORROW = 6'd5, OP_NEG2C = 6'd6, OP_NOT = 6'd7,
        OP_XOR = 6'd8,   OP_AND = 6'd9,   OP_OR = 6'd10,   OP_SHL = 6'd11,
        OP_SHR = 6'd12,  OP_SAR = 6'd13,  OP_MUL = 6'd14,  OP_DIV = 6'd15,
        OP_REM = 6'd16,  OP_SDIV = 6'd17, OP_SREM = 6'd18, OP_BNOT = 6'd19,
        OP_BXOR = 6'd20, OP_BAND = 6'd21, OP_BOR = 6'd22,  OP_EQ = 6'd23,
        OP_NE = 6'd24,   OP_LT = 6'd25,   OP_SLT = 6'd26,  OP_LE = 6'd27,
        OP_SLE = 6'd28,  OP_ZEXT = 6'd29, OP_SEXT = 6'd30, OP_PIECE = 6'd31,
        OP_SUBPIECE = 6'd32
    } t_op;

    // Which unit supplies the final result
    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2,
        K_REM    = 2'd3
    } t_kind;

    // Payload carried alongside the divider
    typedef struct packed {
        t_kind          kind;
        logic           sgnd;
        logic           neg_q;
        logic           neg_r;
        logic           dz;
        logic [1:0]     isz;
        logic [DW-1:0]  simple;
        logic [DW-1:0]  mul;
    } t_side;

    typedef struct packed {
        logic [DW-1:0]  rem;
        logic [DW-1:0]  quo;
        logic [DW-1:0]  dvs;
        t_side          side;
    } t_dstage;

    // Mask for a size code of 1, 2, 4 or 8 bytes
    function automatic logic [DW-1:0] size_mask(logic [1:0] code);
        logic [DW-1:0] m;
        case (code)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

    // Top bit of a value at the given size
    function automatic logic size_msb(logic [DW-1:0] v, logic [1:0] code);
        logic b;
        case (code)
            2'd0:    b = v[7];
            2'd1:    b = v[15];
            2'd2:    b = v[31];
            default: b = v[63];
        endcase
        return b;
    endfunction

    // Sign extension from the given size to 64 bits
    function automatic logic [DW-1:0] sext_from(logic [DW-1:0] v, logic [1:0] code);
        logic [DW-1:0] m;
        m = size_mask(code);
        return size_msb(v, code) ? (v | ~m) : (v & m);
    endfunction

    // One restoring divide step: shift in one dividend bit, subtract if it fits
    function automatic t_dstage div_step(t_dstage s);
        t_dstage     n;
        logic [DW:0] t;
        logic [DW:0] d;
        n = s;
        t = {s.rem, s.quo[DW-1]};
        d = {1'b0, s.dvs};
        if (t >= d) begin
            n.rem = DW'(t - d);
            n.quo = {s.quo[DW-2:0], 1'b1};
        end else begin
            n.rem = t[DW-1:0];
            n.quo = {s.quo[DW-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage

// ===== sv/pcode_integer_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcode_integer_alu
// Integer and boolean P-code ALU, 64-bit operands, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   One operation enters on the slave stream per transfer; one result leaves
//   on the master stream per operation, in order.
//   Slave tdata (low bit up): req_type[5:0], op_a[69:6], op_b[133:70],
//   in_size_code[135:134], out_size_code[137:136], zero pad to 144 bits.
//   Master tdata (low bit up): result_value[63:0], div_zero[64], pad to 72.
//   Path: a result reaches o_m_axis_tvalid through 68 register stages:
//   input register, setup/multiply-partials stage, product-sum stage,
//   64 divider stages, output register.
//   Every operation takes the same path.
//   Throughput: one operation per cycle unless the receiver stalls; the divider
//   retires one quotient bit per stage, so a new divide may enter every cycle.
//   Reset clears all stage valid bits; no output is shown until new input.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and o_s_axis_tready falls; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module pcode_integer_alu
    import pia_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [143:0]  i_s_axis_tdata,   // req_type, op_a, op_b, in_size, out_size
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [71:0]   o_m_axis_tdata    // result_value, div_zero
);

    logic    w_ce;
    logic    w_fv, w_dv;
    t_dstage w_fst, w_dst;

    // Pipeline advances unless a result is waiting on a stalled receiver
    assign w_ce            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_ce;

    pia_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ce            (w_ce),
        .i_valid         (i_s_axis_tvalid),
        .i_req_type      (i_s_axis_tdata[5:0]),
        .i_op_a          (i_s_axis_tdata[69:6]),
        .i_op_b          (i_s_axis_tdata[133:70]),
        .i_in_size_code  (i_s_axis_tdata[135:134]),
        .i_out_size_code (i_s_axis_tdata[137:136]),
        .o_valid         (w_fv),
        .o_stage         (w_fst)
    );

    pia_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_fv),
        .i_stage (w_fst),
        .o_valid (w_dv),
        .o_stage (w_dst)
    );

    // Final select: sign fix and size mask for signed divide/remainder
    logic [DW-1:0] w_res, w_dvr;
    logic          w_neg;

    always_comb begin
        w_dvr = (w_dst.side.kind == K_REM) ? w_dst.rem : w_dst.quo;
        w_neg = (w_dst.side.kind == K_REM) ? w_dst.side.neg_r : w_dst.side.neg_q;
        if (w_dst.side.sgnd) begin
            w_dvr = (w_neg ? '0 - w_dvr : w_dvr) & size_mask(w_dst.side.isz);
        end
        case (w_dst.side.kind)
            K_MUL:        w_res = w_dst.side.mul;
            K_DIV, K_REM: w_res = w_dst.side.dz ? '0 : w_dvr;
            default:      w_res = w_dst.side.simple;
        endcase
    end

    // Output register
    logic          r_ov;
    logic [DW-1:0] r_res;
    logic          r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_ce) begin
            r_ov <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_res <= w_res;
            r_dz  <= w_dst.side.dz;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {7'b0, r_dz, r_res};

    // Checks
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[64] |-> o_m_axis_tdata[63:0] == '0)
        else $error("divide by zero result not cleared");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("pipeline stalled with empty output");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

// ===== sv/pia_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_front
// Input register, simple operations, split multiplier and divider setup.
// ----------------------------------------------------------------------------
module pia_front
    import pia_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ce,
    input  logic            i_valid,
    input  logic [5:0]      i_req_type,
    input  logic [DW-1:0]   i_op_a,
    input  logic [DW-1:0]   i_op_b,
    input  logic [1:0]      i_in_size_code,
    input  logic [1:0]      i_out_size_code,
    output logic            o_valid,
    output t_dstage         o_stage
);

    // Stage 0: input register
    logic          r0_v;
    logic [5:0]    r0_op;
    logic [DW-1:0] r0_a, r0_b;
    logic [1:0]    r0_isz, r0_osz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_ce) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r0_op  <= i_req_type;
            r0_a   <= i_op_a;
            r0_b   <= i_op_b;
            r0_isz <= i_in_size_code;
            r0_osz <= i_out_size_code;
        end
    end

    // Stage 1 logic: results of the simple operations
    logic [DW-1:0] w_im, w_am, w_bm, w_sum, w_dif, w_xa, w_xb, w_simple;
    logic [DW:0]   w_csum;
    logic          w_big_sh, w_sa, w_sb;

    always_comb begin
        w_im     = size_mask(r0_isz);
        w_am     = r0_a & w_im;
        w_bm     = r0_b & w_im;
        w_csum   = {1'b0, w_am} + {1'b0, w_bm};
        w_sum    = r0_a + r0_b;
        w_dif    = r0_a - r0_b;
        w_xa     = sext_from(r0_a, r0_isz);
        w_xb     = sext_from(r0_b, r0_isz);
        w_sa     = size_msb(r0_a, r0_isz);
        w_sb     = size_msb(r0_b, r0_isz);
        w_big_sh = |r0_b[DW-1:6];
        w_simple = '0;
        case (r0_op)
            OP_COPY, OP_ZEXT:     w_simple = r0_a;
            OP_ADD:               w_simple = w_sum;
            OP_SUB:               w_simple = w_dif;
            OP_CARRY:             w_simple = DW'(w_csum > {1'b0, w_im});
            OP_SCARRY:
                w_simple = DW'((w_sa == w_sb) && (size_msb(w_sum, r0_isz) != w_sa));
            OP_SBORROW:
                w_simple = DW'((w_sa != w_sb) && (size_msb(w_dif, r0_isz) != w_sa));
            OP_NEG2C:             w_simple = '0 - r0_a;
            OP_NOT:               w_simple = ~r0_a;
            OP_XOR, OP_BXOR:      w_simple = r0_a ^ r0_b;
            OP_AND, OP_BAND:      w_simple = r0_a & r0_b;
            OP_OR, OP_BOR:        w_simple = r0_a | r0_b;
            OP_SHL:               w_simple = w_big_sh ? '0 : (r0_a << r0_b[5:0]);
            OP_SHR:               w_simple = w_big_sh ? '0 : (r0_a >> r0_b[5:0]);
            OP_SAR:
                w_simple = w_big_sh ? {DW{r0_a[DW-1]}}
                                    : DW'($signed(r0_a) >>> r0_b[5:0]);
            OP_BNOT:              w_simple = DW'(r0_a == '0);
            OP_EQ:                w_simple = DW'(r0_a == r0_b);
            OP_NE:                w_simple = DW'(r0_a != r0_b);
            OP_LT:                w_simple = DW'(r0_a < r0_b);
            OP_LE:                w_simple = DW'(r0_a <= r0_b);
            OP_SLT:               w_simple = DW'($signed(w_xa) < $signed(w_xb));
            OP_SLE:               w_simple = DW'(!($signed(w_xb) < $signed(w_xa)));
            OP_SEXT:              w_simple = w_xa & size_mask(r0_osz);
            OP_PIECE:
                w_simple = (r0_isz == 2'd3) ? r0_a
                                            : (r0_a | (r0_b << (6'd8 << r0_isz)));
            OP_SUBPIECE:
                w_simple = (|r0_b[DW-1:3]) ? '0 : (r0_a >> {r0_b[2:0], 3'b000});
            default:              w_simple = '0;
        endcase
    end

    // Stage 1 logic: divider setup and unit select
    logic          w_sgnd, w_na, w_nb, w_dz;
    logic [DW-1:0] w_dvd, w_dvs;
    t_kind         w_kind;

    always_comb begin
        w_sgnd = (r0_op == OP_SDIV) || (r0_op == OP_SREM);
        w_na   = w_xa[DW-1];
        w_nb   = w_xb[DW-1];
        w_dvd  = w_sgnd ? (w_na ? '0 - w_xa : w_xa) : r0_a;
        w_dvs  = w_sgnd ? (w_nb ? '0 - w_xb : w_xb) : r0_b;
        case (r0_op)
            OP_MUL:           w_kind = K_MUL;
            OP_DIV, OP_SDIV:  w_kind = K_DIV;
            OP_REM, OP_SREM:  w_kind = K_REM;
            default:          w_kind = K_SIMPLE;
        endcase
        w_dz = ((w_kind == K_DIV) || (w_kind == K_REM))
             && (w_sgnd ? (w_bm == '0) : (r0_b == '0));
    end

    // Stage 1 register: partial products and setup
    logic          r1_v;
    logic [DW-1:0] r1_pll;
    logic [31:0]   r1_plh, r1_phl;
    logic [DW-1:0] r1_dvd, r1_dvs;
    t_side         r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_ce) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_pll        <= r0_a[31:0] * r0_b[31:0];
            r1_plh        <= 32'(r0_a[31:0] * r0_b[63:32]);
            r1_phl        <= 32'(r0_a[63:32] * r0_b[31:0]);
            r1_dvd        <= w_dvd;
            r1_dvs        <= w_dvs;
            r1_side.kind  <= w_kind;
            r1_side.sgnd  <= w_sgnd;
            r1_side.neg_q <= w_na ^ w_nb;
            r1_side.neg_r <= w_na;
            r1_side.dz    <= w_dz;
            r1_side.isz   <= r0_isz;
            r1_side.simple <= w_simple;
            r1_side.mul   <= '0;
        end
    end

    // Stage 2 logic: finish the product in the payload
    t_side w_side2;

    always_comb begin
        w_side2     = r1_side;
        w_side2.mul = r1_pll + {r1_plh + r1_phl, 32'b0};
    end

    // Stage 2 register: product sum, divider entry
    logic    r2_v;
    t_dstage r2_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_ce) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_st.rem  <= '0;
            r2_st.quo  <= r1_dvd;
            r2_st.dvs  <= r1_dvs;
            r2_st.side <= w_side2;
        end
    end

    assign o_valid = r2_v;
    assign o_stage = r2_st;

endmodule

// ===== sv/pia_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_div
// Pipelined restoring divider, one quotient bit per stage, payload alongside.
// ----------------------------------------------------------------------------
module pia_div
    import pia_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_ce,
    input  logic     i_valid,
    input  t_dstage  i_stage,
    output logic     o_valid,
    output t_dstage  o_stage
);

    logic    r_v  [1:DIV_STEPS];
    t_dstage r_st [1:DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic    w_pv;
        t_dstage w_pst;

        if (g == 0) begin : g_first
            assign w_pv  = i_valid;
            assign w_pst = i_stage;
        end else begin : g_next
            assign w_pv  = r_v[g];
            assign w_pst = r_st[g];
        end

        // Stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_ce) begin
                r_v[g+1] <= w_pv;
            end
        end

        // One divide step
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_st[g+1] <= div_step(w_pst);
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS];
    assign o_stage = r_st[DIV_STEPS];

endmodule
